[src/sha1_stream_hasher_top_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the SHA-1 stream hasher top level.
// Each one expects clk and arst_n to be visible where it is used.
// ---------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_TOP_MACROS_SVH
`define SHA1_STREAM_HASHER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SHA1SH_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define SHA1SH_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/sha1sh_pkg.sv]
// ---------------------------------------------------------------------------
// sha1sh_pkg
// Codes, constants and controller/datapath command types of the SHA-1 hasher.
// ---------------------------------------------------------------------------
package sha1sh_pkg;

	localparam int NUM_WORDS   = 5;
	localparam int BLOCK_WORDS = 16;

	// Input commands
	localparam logic [1:0] CMD_ABSORB  = 2'd0;
	localparam logic [1:0] CMD_FINISH  = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	// Round groups of twenty rounds each
	localparam logic [1:0] PHASE_CH   = 2'd0;
	localparam logic [1:0] PHASE_PAR1 = 2'd1;
	localparam logic [1:0] PHASE_MAJ  = 2'd2;
	localparam logic [1:0] PHASE_PAR2 = 2'd3;

	localparam logic [2:0] LAST_WORD_IDX = 3'd4;
	localparam logic [7:0] PAD_BYTE      = 8'h80;
	localparam logic [5:0] LEN_OFFSET    = 6'd56;

	localparam logic [31:0] H_INIT [NUM_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	function automatic logic [31:0] round_k(input logic [1:0] phase);
		logic [31:0] k;
		unique case (phase)
			PHASE_CH:   k = 32'h5A827999;
			PHASE_PAR1: k = 32'h6ED9EBA1;
			PHASE_MAJ:  k = 32'h8F1BBCDC;
			default:    k = 32'hCA62C1D6;
		endcase
		return k;
	endfunction

	typedef enum logic [1:0] {
		BSRC_DATA,
		BSRC_PAD,
		BSRC_ZERO,
		BSRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic        push_byte;
		logic        word_push;
		byte_src_t   byte_src;
		logic [2:0]  len_sel;
		logic        len_add;
		logic        len_clear;
		logic        chain_init;
		logic        round_start;
		logic        round_step;
		logic [1:0]  phase;
		logic        chain_add;
		logic        load_status;
		logic [1:0]  status;
		logic        load_word;
		logic [2:0]  word_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic len_wrap;
	} dp_sts_t;

endpackage

[src/sha1sh_in_if.sv]
// ---------------------------------------------------------------------------
// sha1sh_in_if
// Command channel: one command and its message byte per item.
// ---------------------------------------------------------------------------
interface sha1sh_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_byte;

	modport source (output valid, output command, output data_byte, input ready);
	modport sink   (input valid, input command, input data_byte, output ready);
endinterface

[src/sha1sh_out_if.sv]
// ---------------------------------------------------------------------------
// sha1sh_out_if
// Result channel: one digest word or one status item per item.
// ---------------------------------------------------------------------------
interface sha1sh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic [1:0]  status;

	modport source (output valid, output digest_word, output word_index,
		output last_word, output status, input ready);
	modport sink   (input valid, input digest_word, input word_index,
		input last_word, input status, output ready);
endinterface

[src/sha1sh_dp.sv]
// ---------------------------------------------------------------------------
// sha1sh_dp
// Datapath: byte packer, message schedule window, round unit, chaining
// words, bit-length counter and the result register.
// ---------------------------------------------------------------------------
module sha1sh_dp import sha1sh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        data_byte,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	sha1sh_out_if.source      rsp
);

	logic [31:0] chain_q [NUM_WORDS];
	logic [31:0] w_q [BLOCK_WORDS];
	logic [23:0] acc_q;
	logic [63:0] len_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;

	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_idx_q;
	logic        out_last_q;
	logic [1:0]  out_status_q;

	logic [7:0]  byte_val;
	logic [31:0] f_val;
	logic [31:0] t_val;
	logic [31:0] w_next;

	always_comb begin
		unique case (cmd.byte_src)
			BSRC_DATA: byte_val = data_byte;
			BSRC_PAD:  byte_val = PAD_BYTE;
			BSRC_ZERO: byte_val = 8'h00;
			default:   byte_val = len_q[{~cmd.len_sel, 3'b000} +: 8];
		endcase
	end

	always_comb begin
		unique case (cmd.phase)
			PHASE_CH:  f_val = (b_q & c_q) | (~b_q & d_q);
			PHASE_MAJ: f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			default:   f_val = b_q ^ c_q ^ d_q;
		endcase
	end

	logic [31:0] w_mix;
	assign w_mix  = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_next = {w_mix[30:0], w_mix[31]};
	assign t_val  = {a_q[26:0], a_q[31:27]} + f_val + e_q + w_q[0] + round_k(cmd.phase);

	// Schedule window and round registers carry no reset
	always_ff @(posedge clk) begin
		if (cmd.push_byte) begin
			acc_q <= {acc_q[15:0], byte_val};
		end
		if (cmd.round_step) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BLOCK_WORDS - 1] <= w_next;
		end else if (cmd.push_byte && cmd.word_push) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BLOCK_WORDS - 1] <= {acc_q, byte_val};
		end
		if (cmd.round_start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (cmd.round_step) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t_val;
		end
		if (cmd.load_status) begin
			out_word_q   <= '0;
			out_idx_q    <= '0;
			out_last_q   <= 1'b1;
			out_status_q <= cmd.status;
		end else if (cmd.load_word) begin
			out_word_q   <= chain_q[cmd.word_idx];
			out_idx_q    <= cmd.word_idx;
			out_last_q   <= (cmd.word_idx == LAST_WORD_IDX);
			out_status_q <= ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				chain_q[i] <= H_INIT[i];
			end
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.chain_init) begin
				for (int i = 0; i < NUM_WORDS; i++) begin
					chain_q[i] <= H_INIT[i];
				end
			end else if (cmd.chain_add) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (cmd.len_clear) begin
				len_q <= '0;
			end else if (cmd.len_add) begin
				len_q <= {len_q[63:3] + 61'd1, 3'b000};
			end
			if (cmd.load_status || cmd.load_word) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || rsp.ready;
	assign sts.len_wrap = &len_q[63:3];

	assign rsp.valid       = out_valid_q;
	assign rsp.digest_word = out_word_q;
	assign rsp.word_index  = out_idx_q;
	assign rsp.last_word   = out_last_q;
	assign rsp.status      = out_status_q;

endmodule

[src/sha1sh_ctrl.sv]
// ---------------------------------------------------------------------------
// sha1sh_ctrl
// Controller: command decode, fill count, padding sequence, round counter
// and digest read-out.
// ---------------------------------------------------------------------------
module sha1sh_ctrl import sha1sh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  logic [1:0] command,
	output logic       ready,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1;
	localparam logic [2:0] S_PADZ  = 3'd2;
	localparam logic [2:0] S_LEN   = 3'd3;
	localparam logic [2:0] S_ROUND = 3'd4;
	localparam logic [2:0] S_FOLD  = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [6:0] ROUND_LAST = 7'd79;

	logic [2:0] state_q, state_d;
	logic [5:0] fill_q, fill_d;
	logic [6:0] round_q, round_d;
	logic [2:0] widx_q, widx_d;
	logic       pad_q, pad_d;
	logic       lenblk_q, lenblk_d;
	logic       done_q, done_d;
	logic       sticky_q, sticky_d;
	logic       accept;

	assign ready  = (state_q == S_IDLE) && sts.out_free;
	assign accept = valid && ready;

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		round_d  = round_q;
		widx_d   = widx_q;
		pad_d    = pad_q;
		lenblk_d = lenblk_q;
		done_d   = done_q;
		sticky_d = sticky_q;
		cmd      = '0;
		cmd.byte_src  = BSRC_DATA;
		cmd.len_sel   = fill_q[2:0];
		cmd.word_push = (fill_q[1:0] == 2'b11);
		cmd.word_idx  = widx_q;
		if (round_q < 7'd20) begin
			cmd.phase = PHASE_CH;
		end else if (round_q < 7'd40) begin
			cmd.phase = PHASE_PAR1;
		end else if (round_q < 7'd60) begin
			cmd.phase = PHASE_MAJ;
		end else begin
			cmd.phase = PHASE_PAR2;
		end

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (command)
						CMD_ABSORB: begin
							cmd.load_status = 1'b1;
							if (done_q) begin
								sticky_d   = 1'b1;
								cmd.status = ST_INVALID;
							end else if (sticky_q) begin
								cmd.status = ST_INVALID;
							end else begin
								cmd.push_byte = 1'b1;
								cmd.len_add   = 1'b1;
								fill_d        = fill_q + 6'd1;
								if (sts.len_wrap) begin
									// length wrapped: keep the byte, skip compression
									sticky_d   = 1'b1;
									cmd.status = ST_TOO_LONG;
								end else begin
									cmd.status = ST_OK;
									if (fill_q == FILL_LAST) begin
										cmd.round_start = 1'b1;
										round_d         = '0;
										state_d         = S_ROUND;
									end
								end
							end
						end
						CMD_FINISH: begin
							if (sticky_q) begin
								cmd.load_status = 1'b1;
								cmd.status      = ST_INVALID;
							end else if (done_q) begin
								widx_d  = '0;
								state_d = S_EMIT;
							end else begin
								pad_d   = 1'b1;
								state_d = S_PAD;
							end
						end
						CMD_RESTART: begin
							cmd.chain_init  = 1'b1;
							cmd.len_clear   = 1'b1;
							cmd.load_status = 1'b1;
							cmd.status      = ST_OK;
							fill_d          = '0;
							done_d          = 1'b0;
							sticky_d        = 1'b0;
						end
						default: begin
							cmd.load_status = 1'b1;
							cmd.status      = ST_INVALID;
						end
					endcase
				end
			end
			S_PAD: begin
				cmd.push_byte = 1'b1;
				cmd.byte_src  = BSRC_PAD;
				fill_d        = fill_q + 6'd1;
				if (fill_q == FILL_LAST) begin
					cmd.round_start = 1'b1;
					round_d         = '0;
					state_d         = S_ROUND;
				end else begin
					state_d = S_PADZ;
				end
			end
			S_PADZ: begin
				if (fill_q == LEN_OFFSET) begin
					state_d = S_LEN;
				end else begin
					cmd.push_byte = 1'b1;
					cmd.byte_src  = BSRC_ZERO;
					fill_d        = fill_q + 6'd1;
					if (fill_q == FILL_LAST) begin
						cmd.round_start = 1'b1;
						round_d         = '0;
						state_d         = S_ROUND;
					end
				end
			end
			S_LEN: begin
				cmd.push_byte = 1'b1;
				cmd.byte_src  = BSRC_LEN;
				fill_d        = fill_q + 6'd1;
				if (fill_q == FILL_LAST) begin
					lenblk_d        = 1'b1;
					cmd.round_start = 1'b1;
					round_d         = '0;
					state_d         = S_ROUND;
				end
			end
			S_ROUND: begin
				cmd.round_step = 1'b1;
				round_d        = round_q + 7'd1;
				if (round_q == ROUND_LAST) begin
					state_d = S_FOLD;
				end
			end
			S_FOLD: begin
				cmd.chain_add = 1'b1;
				if (!pad_q) begin
					state_d = S_IDLE;
				end else if (lenblk_q) begin
					// final block folded: the digest is ready
					cmd.len_clear = 1'b1;
					pad_d         = 1'b0;
					lenblk_d      = 1'b0;
					done_d        = 1'b1;
					fill_d        = '0;
					widx_d        = '0;
					state_d       = S_EMIT;
				end else begin
					state_d = S_PADZ;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.load_word = 1'b1;
					if (widx_q == LAST_WORD_IDX) begin
						state_d = S_IDLE;
					end else begin
						widx_d = widx_q + 3'd1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			round_q  <= '0;
			widx_q   <= '0;
			pad_q    <= 1'b0;
			lenblk_q <= 1'b0;
			done_q   <= 1'b0;
			sticky_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			round_q  <= round_d;
			widx_q   <= widx_d;
			pad_q    <= pad_d;
			lenblk_q <= lenblk_d;
			done_q   <= done_d;
			sticky_q <= sticky_d;
		end
	end

endmodule

[src/sha1_stream_hasher_top.sv]
// ---------------------------------------------------------------------------
// sha1_stream_hasher_top
// Byte-serial SHA-1 hasher: controller plus datapath.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one command per item: absorb a message byte, finish and read
//   the digest, or restart a new message. rsp returns one result item per
//   absorb, restart or failed finish, and five digest words (index 0 to 4,
//   last_word on index 4) per successful finish.
//   An absorb's status item appears on rsp in the cycle after the absorb is
//   taken. Every 64th byte starts the round unit, which runs one round per
//   cycle: 80 rounds and then a fold into the chaining words, and req is held
//   off until the fold is done. A finish pushes the padding and length bytes
//   through the block packer, runs one or two compressions and then sends
//   the five words, with req held off throughout. A repeated finish sends
//   the stored digest again.
//   rsp has one output register; req is taken only while it is empty or being
//   read, so a stalled receiver holds the block and loses nothing.
//   Reset loads the initial chaining words and clears the length, fill count
//   and error flags; the block is ready as soon as reset is released.
// ---------------------------------------------------------------------------
`include "sha1_stream_hasher_top_macros.svh"

module sha1_stream_hasher_top import sha1sh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	sha1sh_in_if.sink    req,
	sha1sh_out_if.source rsp
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;
	logic    req_ready;

	assign req.ready = req_ready;

	sha1sh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (req.valid),
		.command (req.command),
		.ready   (req_ready),
		.sts     (dp_sts),
		.cmd     (dp_cmd)
	);

	sha1sh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (req.data_byte),
		.cmd       (dp_cmd),
		.sts       (dp_sts),
		.rsp       (rsp)
	);

	`SHA1SH_ASSERT_IMP(a_no_accept_when_full, req.valid && req.ready, !rsp.valid || rsp.ready, "item accepted while result register is blocked")
	`SHA1SH_ASSERT_IMP(a_mid_word_ok, rsp.valid && !rsp.last_word, rsp.status == ST_OK && rsp.word_index != LAST_WORD_IDX, "non-final result is not a plain digest word")
	`SHA1SH_ASSERT_IMP(a_error_is_last, rsp.valid && rsp.status != ST_OK, rsp.last_word, "error status on a non-final result")
	`SHA1SH_ASSERT_NXT(a_digest_follows, rsp.valid && rsp.ready && !rsp.last_word, rsp.valid, "gap inside digest read-out")

endmodule
